// ----- design/char_stream_tokenizer_macros.svh -----
// ----------------------------------------------------------------------------
// char_stream_tokenizer assertion macros
// Shorthand for clocked, reset-gated concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CHAR_STREAM_TOKENIZER_MACROS_SVH
`define CHAR_STREAM_TOKENIZER_MACROS_SVH

// same-cycle implication
`define CST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ----- design/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// Types, token codes and character classes shared by the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

    localparam int PUNCT_COUNT = 32;
    localparam int MINUS_INDEX = 12;
    localparam int KIND_W      = 6;
    localparam int LEN_W       = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam longint MAX_TOKEN_LENGTH = 65535;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [LEN_W-1:0]  t_len;

    localparam t_len LEN_CAP = (MAX_TOKEN_LENGTH < 65535) ?
                               t_len'(MAX_TOKEN_LENGTH) : 16'hFFFF;

    localparam t_kind KIND_END        = 6'd0;
    localparam t_kind KIND_SPACE      = 6'd1;
    localparam t_kind KIND_NUMBER     = 6'd2;
    localparam t_kind KIND_TEXT       = 6'd3;
    localparam t_kind KIND_PUNCT_BASE = 6'd4;
    localparam t_kind KIND_MINUS      = KIND_PUNCT_BASE + KIND_W'(MINUS_INDEX);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // ` ~ ! @ # $ % ^ & * ( ) - _ = + [ { ] } ; : ' " \ | , < . > / ?
    localparam logic [7:0] PUNCT_BYTES [PUNCT_COUNT] = '{
        8'h60, 8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h5F, 8'h3D, 8'h2B,
        8'h5B, 8'h7B, 8'h5D, 8'h7D, 8'h3B, 8'h3A, 8'h27, 8'h22,
        8'h5C, 8'h7C, 8'h2C, 8'h3C, 8'h2E, 8'h3E, 8'h2F, 8'h3F
    };

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_SPACE  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_TEXT   = 3'd3,
        MODE_MINUS  = 3'd4
    } t_mode;

    typedef struct packed {
        logic hit;
        t_kind kind;
    } t_punct;

    // one queue entry: the results caused by one input item
    typedef struct packed {
        logic  two;
        t_kind kind0;
        t_len  len0;
        t_kind kind1;
        t_len  len1;
    } t_entry;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_LF, CH_CR, CH_TAB};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic t_len grow(input t_len len);
        return (len < LEN_CAP) ? len + t_len'(1) : LEN_CAP;
    endfunction

    function automatic t_punct punct_lookup(input logic [7:0] c);
        t_punct r;
        r.hit  = 1'b0;
        r.kind = KIND_TEXT;
        for (int i = 0; i < PUNCT_COUNT; i++) begin
            if (!r.hit && PUNCT_BYTES[i] == c) begin
                r.hit  = 1'b1;
                r.kind = KIND_PUNCT_BASE + KIND_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/char_stream_tokenizer.sv -----
// ----------------------------------------------------------------------------
// char_stream_tokenizer
// Splits a byte stream into whitespace, number, text, punctuation and end
// tokens, each reported with its kind and length.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         i_valid / o_ready      i_character
//  result    out        o_valid / i_ready      o_token_kind, o_token_length,
//                                              o_last_of_run
//  config    in         i_cfg_we               i_cfg_wdata
//
//  One byte per cycle is accepted; the front classifies it in the accept cycle.
//  Results leave the back's output register one per cycle while i_ready is
//  high, so a byte that closes a token and emits another yields two results.
//  A four-entry queue sits between front and back; o_ready drops when it fills.
//  Reset (synchronous, active low) empties the queue and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_stream_tokenizer_macros.svh"

module char_stream_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_character,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);
    import cst_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry push_entry;
    t_entry head_entry;

    cst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_character (i_character),
        .i_full      (full),
        .o_ready     (o_ready),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    cst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    cst_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (head_entry),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_token_kind   (o_token_kind),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    `CST_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, push, !full)
    `CST_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, pop, !empty)
    `CST_ASSERT_NOW(a_end_len, i_clk, i_rst_n, o_valid && o_token_kind == KIND_END,
        o_token_length == '0 && o_last_of_run)
    `CST_ASSERT_NOW(a_punct_len, i_clk, i_rst_n, o_valid && o_token_kind >= KIND_PUNCT_BASE,
        o_token_length == t_len'(1))

endmodule

`default_nettype wire

// ----- design/cst_front.sv -----
// ----------------------------------------------------------------------------
// cst_front
// Accepts bytes, tracks the open token and builds the results of each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_valid,
    input  logic [7:0]      i_character,
    input  logic            i_full,
    output logic            o_ready,
    output logic            o_push,
    output cst_pkg::t_entry o_entry
);
    import cst_pkg::*;

    t_mode  r_mode, n_mode;
    t_len   r_len, n_len;
    logic   r_skip_ws;

    logic   accept;
    logic   close_keep;
    t_kind  close_kind;
    t_len   close_len;
    logic   do_begin;
    logic   beg_emit;
    t_kind  beg_kind;
    t_len   beg_len;
    t_mode  beg_mode;
    t_len   beg_run;
    logic   beg_out;
    t_punct punct;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign punct   = punct_lookup(i_character);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_len     <= '0;
            r_skip_ws <= 1'b0;
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_len  <= n_len;
            end
            if (i_cfg_we) begin
                r_skip_ws <= i_cfg_wdata;
            end
        end
    end

    // start of a new token
    always_comb begin
        beg_emit = 1'b0;
        beg_kind = KIND_END;
        beg_len  = '0;
        beg_mode = MODE_IDLE;
        beg_run  = '0;
        if (i_character == CH_NUL) begin
            beg_emit = 1'b1;
        end else if (is_space(i_character)) begin
            beg_mode = MODE_SPACE;
            beg_run  = t_len'(1);
        end else if (is_digit(i_character)) begin
            beg_mode = MODE_NUMBER;
            beg_run  = t_len'(1);
        end else if (i_character == CH_MINUS) begin
            beg_mode = MODE_MINUS;
            beg_run  = t_len'(1);
        end else if (punct.hit) begin
            beg_emit = 1'b1;
            beg_kind = punct.kind;
            beg_len  = t_len'(1);
        end else begin
            beg_mode = MODE_TEXT;
            beg_run  = t_len'(1);
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_len      = r_len;
        close_keep = 1'b0;
        close_kind = KIND_END;
        close_len  = r_len;
        do_begin   = 1'b0;
        case (r_mode)
            MODE_SPACE: begin
                if (is_space(i_character)) begin
                    n_len = grow(r_len);
                end else begin
                    close_keep = !r_skip_ws;
                    close_kind = KIND_SPACE;
                    do_begin   = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(i_character) || i_character == CH_PERIOD) begin
                    n_len = grow(r_len);
                end else begin
                    close_keep = 1'b1;
                    close_kind = KIND_NUMBER;
                    do_begin   = 1'b1;
                end
            end
            MODE_TEXT: begin
                if (i_character != CH_NUL && !is_space(i_character)) begin
                    n_len = grow(r_len);
                end else begin
                    close_keep = 1'b1;
                    close_kind = KIND_TEXT;
                    do_begin   = 1'b1;
                end
            end
            MODE_MINUS: begin
                if (is_digit(i_character)) begin
                    n_mode = MODE_NUMBER;
                    n_len  = grow(t_len'(1));
                end else begin
                    close_keep = 1'b1;
                    close_kind = KIND_MINUS;
                    close_len  = t_len'(1);
                    do_begin   = 1'b1;
                end
            end
            default: begin
                do_begin = 1'b1;
            end
        endcase
        if (do_begin) begin
            n_mode = beg_mode;
            n_len  = beg_run;
        end
    end

    assign beg_out = do_begin && beg_emit;
    assign o_push  = accept && (close_keep || beg_out);

    always_comb begin
        o_entry.two   = close_keep && beg_out;
        o_entry.kind0 = close_keep ? close_kind : beg_kind;
        o_entry.len0  = close_keep ? close_len : beg_len;
        o_entry.kind1 = beg_kind;
        o_entry.len1  = beg_len;
    end

endmodule

`default_nettype wire

// ----- design/cst_queue.sv -----
// ----------------------------------------------------------------------------
// cst_queue
// Short FIFO of result entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cst_pkg::t_entry i_entry,
    input  logic            i_pop,
    output cst_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);
    import cst_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/cst_back.sv -----
// ----------------------------------------------------------------------------
// cst_back
// Pops queue entries and delivers their results one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cst_pkg::t_entry       i_entry,
    input  logic                  i_empty,
    output logic                  o_pop,
    input  logic                  i_ready,
    output logic                  o_valid,
    output cst_pkg::t_kind        o_token_kind,
    output cst_pkg::t_len         o_token_length,
    output logic                  o_last_of_run
);
    import cst_pkg::*;

    logic  r_valid;
    logic  r_pend;
    t_kind r_kind;
    t_len  r_len;
    logic  r_last;
    t_kind r_pend_kind;
    t_len  r_pend_len;
    logic  load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_pend && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_empty;
                r_pend  <= !i_empty && i_entry.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_kind <= r_pend_kind;
                r_len  <= r_pend_len;
                r_last <= 1'b1;
            end else begin
                r_kind      <= i_entry.kind0;
                r_len       <= i_entry.len0;
                r_last      <= !i_entry.two;
                r_pend_kind <= i_entry.kind1;
                r_pend_len  <= i_entry.len1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_token_kind   = r_kind;
    assign o_token_length = r_len;
    assign o_last_of_run  = r_last;

endmodule

`default_nettype wire

// ----- dv/tb_char_stream_tokenizer.sv -----
// ----------------------------------------------------------------------------
// tb_char_stream_tokenizer
// Feeds byte streams into the tokenizer and checks every token it reports.
// A clocked driver offers bytes from a queue and tokenizes each accepted byte
// in its own scanner model. A clocked monitor takes tokens and compares kind,
// length and the last-of-run flag in order. The run covers directed corner
// cases, random token streams under both whitespace settings, random stalls,
// a stretch with no stalls, and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_char_stream_tokenizer;

    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTS   = 100;

    typedef struct {
        t_kind kind;
        t_len  length;
        logic  last;
    } t_token;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       cfg_we      = 1'b0;
    logic       cfg_wdata   = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] in_char     = 8'h00;
    logic       out_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [5:0] o_token_kind;
    logic [15:0] o_token_length;
    logic       o_last_of_run;

    logic [7:0] byte_queue [$];
    t_token     expected_tokens [$];
    t_kind      step_kinds [$];
    t_len       step_lens [$];

    t_mode      scan_mode_m  = MODE_IDLE;
    t_len       run_len_m    = '0;
    logic       skip_ws_m    = 1'b0;

    int         bytes_queued   = 0;
    int         bytes_accepted = 0;
    int         mismatches     = 0;
    int         cycle_count    = 0;
    int         src_idle_pct   = 22;
    int         sink_idle_pct  = 22;
    logic       hold_go        = 1'b0;
    logic       sink_hold      = 1'b0;

    char_stream_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_valid        (in_valid),
        .o_ready        (o_ready),
        .i_character    (in_char),
        .o_valid        (o_valid),
        .i_ready        (out_ready),
        .o_token_kind   (o_token_kind),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------
    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int symbol_index(input logic [7:0] c);
        case (c)
            8'h60: return 0;   8'h7E: return 1;   8'h21: return 2;   8'h40: return 3;
            8'h23: return 4;   8'h24: return 5;   8'h25: return 6;   8'h5E: return 7;
            8'h26: return 8;   8'h2A: return 9;   8'h28: return 10;  8'h29: return 11;
            8'h2D: return 12;  8'h5F: return 13;  8'h3D: return 14;  8'h2B: return 15;
            8'h5B: return 16;  8'h7B: return 17;  8'h5D: return 18;  8'h7D: return 19;
            8'h3B: return 20;  8'h3A: return 21;  8'h27: return 22;  8'h22: return 23;
            8'h5C: return 24;  8'h7C: return 25;  8'h2C: return 26;  8'h3C: return 27;
            8'h2E: return 28;  8'h3E: return 29;  8'h2F: return 30;  8'h3F: return 31;
            default: return -1;
        endcase
    endfunction

    function automatic t_len next_len(input t_len l);
        return (l == 16'hFFFF) ? l : l + 16'd1;
    endfunction

    function automatic t_kind symbol_kind(input logic [7:0] c);
        return KIND_PUNCT_BASE + t_kind'(symbol_index(c));
    endfunction

    task automatic note_token(input t_kind kind, input t_len length);
        step_kinds.push_back(kind);
        step_lens.push_back(length);
    endtask

    task automatic open_token(input logic [7:0] c);
        scan_mode_m = MODE_IDLE;
        run_len_m   = '0;
        if (c == CH_NUL) begin
            note_token(KIND_END, '0);
        end else if (is_blank(c)) begin
            scan_mode_m = MODE_SPACE;
            run_len_m   = 16'd1;
        end else if (is_numeral(c)) begin
            scan_mode_m = MODE_NUMBER;
            run_len_m   = 16'd1;
        end else if (c == CH_MINUS) begin
            scan_mode_m = MODE_MINUS;
            run_len_m   = 16'd1;
        end else if (symbol_index(c) >= 0) begin
            note_token(symbol_kind(c), 16'd1);
        end else begin
            scan_mode_m = MODE_TEXT;
            run_len_m   = 16'd1;
        end
    endtask

    task automatic close_token(input t_kind kind, input logic keep, input logic [7:0] c);
        if (keep) begin
            note_token(kind, run_len_m);
        end
        open_token(c);
    endtask

    task automatic tokenize_byte(input logic [7:0] c);
        t_token t;
        step_kinds.delete();
        step_lens.delete();
        case (scan_mode_m)
            MODE_SPACE: begin
                if (is_blank(c)) run_len_m = next_len(run_len_m);
                else close_token(KIND_SPACE, !skip_ws_m, c);
            end
            MODE_NUMBER: begin
                if (is_numeral(c) || c == CH_PERIOD) run_len_m = next_len(run_len_m);
                else close_token(KIND_NUMBER, 1'b1, c);
            end
            MODE_TEXT: begin
                if (c != CH_NUL && !is_blank(c)) run_len_m = next_len(run_len_m);
                else close_token(KIND_TEXT, 1'b1, c);
            end
            MODE_MINUS: begin
                if (is_numeral(c)) begin
                    scan_mode_m = MODE_NUMBER;
                    run_len_m   = 16'd2;
                end else begin
                    run_len_m = 16'd1;
                    close_token(symbol_kind(CH_MINUS), 1'b1, c);
                end
            end
            default: open_token(c);
        endcase
        for (int i = 0; i < step_kinds.size(); i++) begin
            t.kind   = step_kinds[i];
            t.length = step_lens[i];
            t.last   = (i == step_kinds.size() - 1);
            expected_tokens.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("[%0t] token mismatch on %s: got %0d, want %0d", $realtime, what,
                     got, want);
        end
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_ready) begin
                tokenize_byte(in_char);
                bytes_accepted++;
            end
            if (!in_valid || o_ready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_valid <= 1'b1;
                    in_char  <= byte_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_valid && out_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected token kind", o_token_kind, -1);
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_token_kind !== want.kind)
                        report_mismatch("kind", o_token_kind, want.kind);
                    if (o_token_length !== want.length)
                        report_mismatch("length", o_token_length, want.length);
                    if (o_last_of_run !== want.last)
                        report_mismatch("last_of_run", o_last_of_run, want.last);
                end
            end
            out_ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : sink_hold_ctrl
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] c);
        byte_queue.push_back(c);
        bytes_queued++;
    endtask

    function automatic logic [7:0] any_blank();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_LF;
            2: return CH_CR;
            default: return CH_TAB;
        endcase
    endfunction

    function automatic logic [7:0] any_symbol();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126)); while (symbol_index(c) < 0);
        return c;
    endfunction

    function automatic logic [7:0] text_start();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (is_blank(c) || is_numeral(c) || symbol_index(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] text_body();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (is_blank(c));
        return c;
    endfunction

    task automatic add_random_token();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 22) begin
            if ($urandom_range(1)) queue_byte(CH_MINUS);
            queue_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
            n = $urandom_range(7);
            repeat (n) begin
                if ($urandom_range(4) == 0) queue_byte(CH_PERIOD);
                else queue_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
        end else if (r < 40) begin
            queue_byte(text_start());
            n = $urandom_range(10);
            repeat (n) queue_byte(text_body());
        end else if (r < 60) begin
            n = $urandom_range(1, 5);
            repeat (n) queue_byte(any_blank());
        end else if (r < 75) begin
            queue_byte(any_symbol());
        end else if (r < 80) begin
            queue_byte(CH_MINUS);
            queue_byte(8'($urandom_range(255)));
        end else if (r < 85) begin
            queue_byte(CH_NUL);
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) queue_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic add_random_stream(input int count);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < count) add_random_token();
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_skip(input logic v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        skip_ws_m = v;
    endtask

    initial begin : stimulus
        logic [7:0] opening [$];
        opening = '{
            8'h00,                      // end in idle
            8'h20, 8'h09, 8'h0D, 8'h0A, // every blank
            8'h2D, 8'h35, 8'h2E, 8'h33, // minus into number
            8'h2C,                      // number closed by a symbol
            8'h2D, 8'h78,               // minus then text
            8'h7A, 8'h39, 8'h3B,        // digit and symbol inside text
            8'h20,
            8'h2D, 8'h2D,               // minus then minus
            8'h2E, 8'h2E,               // leading periods
            8'hFF, 8'h80, 8'h01,        // high and low text bytes
            8'h00                       // end flushes text
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_skip(1'b0);
        foreach (opening[i]) queue_byte(opening[i]);
        wait_idle();

        write_skip(1'b1);
        add_random_stream(300);
        wait_idle();

        // burst with no stalls on either side
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
        write_skip(1'b0);
        add_random_stream(300);
        wait_idle();
        src_idle_pct  <= 22;
        sink_idle_pct <= 22;

        // hold the output while bytes keep coming
        write_skip(1'b1);
        hold_go <= 1'b1;
        add_random_stream(130);
        wait_idle();
        add_random_stream(120);
        wait_idle();

        write_skip(1'b0);
        add_random_stream(300);
        wait_idle();

        if (expected_tokens.size() != 0)
            report_mismatch("tokens left over", expected_tokens.size(), 0);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
